[rtl/i2c_master_register_access_top_assert.svh]
// ----------------------------------------------------------------------------
// i2c master register access - assertion macros
// concurrent checks that compile away when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_REGISTER_ACCESS_TOP_ASSERT_SVH
`define I2C_MASTER_REGISTER_ACCESS_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// a holds at an edge, b must hold at the same edge
`define I2CMRA_ASSERT_SAME(label, clk, rst_n, a, b, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error(msg);

// a holds at an edge, b must hold at the next edge
`define I2CMRA_ASSERT_NEXT(label, clk, rst_n, a, b, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error(msg);

`else

`define I2CMRA_ASSERT_SAME(label, clk, rst_n, a, b, msg)
`define I2CMRA_ASSERT_NEXT(label, clk, rst_n, a, b, msg)

`endif

`endif

[rtl/i2cmra_pkg.sv]
// ----------------------------------------------------------------------------
// i2cmra_pkg
// types and constants of the i2c master register access block
// ----------------------------------------------------------------------------
package i2cmra_pkg;

	typedef logic [1:0] action_t;
	typedef logic [7:0] byte_t;

	// request codes
	localparam action_t ACTION_TICK  = 2'd0;
	localparam action_t ACTION_WRITE = 2'd1;
	localparam action_t ACTION_READ  = 2'd2;

	// which byte of the transaction is being sent
	typedef logic [1:0] step_t;
	localparam step_t STEP_DEVICE   = 2'd0;
	localparam step_t STEP_REGISTER = 2'd1;
	localparam step_t STEP_PAYLOAD  = 2'd2;

	localparam byte_t      ACK_TIMEOUT_RESET = 8'd250;
	localparam logic [3:0] BITS_PER_BYTE     = 4'd8;

endpackage

[rtl/i2c_master_register_access_top.sv]
// ----------------------------------------------------------------------------
// i2c_master_register_access_top
// i2c master for single-byte register writes and reads, one bus-phase tick
// per request
// ----------------------------------------------------------------------------
//
//  channel   | handshake               | payload
//  ----------+-------------------------+-----------------------------------------
//  request   | in_valid / in_stall     | action, device_address, register_address,
//            |                         | write_data, sda_in
//  result    | out_valid / out_stall   | scl_level, sda_level, busy_res, done_res,
//            |                         | ack_failed, read_value
//  config    | cfg_we / cfg_wdata      | ack_timeout
//
//  - one request per clock sustained while out_stall is low; a request waits in the
//    input register and its result is written to the result register as it leaves
//  - the bus state machine advances once per request, in the cycle the
//    request leaves the input register; that single step sets the rate
//  - a full result register that is stalled holds the input register, which
//    then raises in_stall; the two stages keep requests flowing otherwise
//  - arst_n clears the state machine, the timeout register (to 250) and the
//    received byte; no clearing pass is needed
//
module i2c_master_register_access_top (
	input  logic                clk,
	input  logic                arst_n,
	// request channel
	input  logic                in_valid,
	output logic                in_stall,
	input  i2cmra_pkg::action_t action,
	input  i2cmra_pkg::byte_t   device_address,
	input  i2cmra_pkg::byte_t   register_address,
	input  i2cmra_pkg::byte_t   write_data,
	input  logic                sda_in,
	// result channel
	output logic                out_valid,
	input  logic                out_stall,
	output logic                scl_level,
	output logic                sda_level,
	output logic                busy_res,
	output logic                done_res,
	output logic                ack_failed,
	output i2cmra_pkg::byte_t   read_value,
	// timeout register
	input  logic                cfg_we,
	input  i2cmra_pkg::byte_t   cfg_wdata
);
	import i2cmra_pkg::*;

	`include "i2c_master_register_access_top_assert.svh"

	// bus phases, one per tick
	typedef enum logic [3:0] {
		PH_IDLE,
		PH_RESTART_LOW,
		PH_START_HIGH,
		PH_START_FALL,
		PH_START_LOW,
		PH_BIT_LOW,
		PH_BIT_HIGH,
		PH_ACK_RELEASE,
		PH_ACK_WAIT,
		PH_RD_LOW,
		PH_RD_HIGH,
		PH_NACK_LOW,
		PH_NACK_HIGH,
		PH_STOP_LOW,
		PH_STOP_RISE,
		PH_STOP_END
	} phase_t;

	// input register
	logic      valid_s1;
	action_t   action_s1;
	byte_t     dev_s1;
	byte_t     reg_s1;
	byte_t     data_s1;
	logic      sda_in_s1;

	// result register
	logic      valid_s2;
	logic      scl_s2;
	logic      sda_s2;
	logic      busy_s2;
	logic      done_s2;
	logic      failed_s2;
	byte_t     rx_s2;

	// bus state
	phase_t     phase_q;
	logic [3:0] bit_cnt_q;
	step_t      step_q;
	byte_t      shift_q;
	byte_t      wait_cnt_q;
	logic       req_rd_q;
	byte_t      req_dev_q;
	byte_t      req_reg_q;
	byte_t      req_data_q;
	byte_t      rx_byte_q;
	logic       fail_q;
	byte_t      ack_timeout_q;

	// next state and result of the step
	phase_t     phase_d;
	logic [3:0] bit_cnt_d;
	step_t      step_d;
	byte_t      shift_d;
	byte_t      wait_cnt_d;
	logic       req_rd_d;
	byte_t      req_dev_d;
	byte_t      req_reg_d;
	byte_t      req_data_d;
	byte_t      rx_byte_d;
	logic       fail_d;
	logic       scl_d;
	logic       sda_d;
	logic       busy_d;
	logic       done_d;
	logic       failed_d;

	logic       advance;
	logic       in_accept;

	// the request in the input register moves on when the result register
	// is empty or is being read this cycle
	assign advance   = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall  = valid_s1 && !advance;
	assign in_accept = in_valid && !in_stall;

	// byte sent at a given step of the latched transaction
	function automatic byte_t byte_for_step(input step_t step, input logic rd,
			input byte_t dev, input byte_t regb, input byte_t data);
		byte_t b;
		case (step)
			STEP_DEVICE:   b = dev;
			STEP_REGISTER: b = regb;
			default:       b = rd ? byte_t'(dev + 8'd1) : data;
		endcase
		return b;
	endfunction

	// one bus tick
	always_comb begin
		phase_t ph;
		ph          = phase_q;
		phase_d     = phase_q;
		bit_cnt_d   = bit_cnt_q;
		step_d      = step_q;
		shift_d     = shift_q;
		wait_cnt_d  = wait_cnt_q;
		req_rd_d    = req_rd_q;
		req_dev_d   = req_dev_q;
		req_reg_d   = req_reg_q;
		req_data_d  = req_data_q;
		rx_byte_d   = rx_byte_q;
		fail_d      = fail_q;
		scl_d       = 1'b1;
		sda_d       = 1'b1;
		busy_d      = 1'b1;
		done_d      = 1'b0;
		failed_d    = 1'b0;

		// a start request on an idle tick opens the transaction at once
		if (phase_q == PH_IDLE &&
				(action_s1 == ACTION_WRITE || action_s1 == ACTION_READ)) begin
			req_rd_d   = (action_s1 == ACTION_READ);
			req_dev_d  = dev_s1;
			req_reg_d  = reg_s1;
			req_data_d = data_s1;
			step_d     = STEP_DEVICE;
			bit_cnt_d  = '0;
			wait_cnt_d = '0;
			fail_d     = 1'b0;
			ph         = PH_START_HIGH;
		end

		case (ph)
			PH_RESTART_LOW: begin
				scl_d   = 1'b0;
				phase_d = PH_START_HIGH;
			end
			PH_START_HIGH: begin
				phase_d = PH_START_FALL;
			end
			PH_START_FALL: begin
				sda_d   = 1'b0;
				phase_d = PH_START_LOW;
			end
			PH_START_LOW: begin
				scl_d     = 1'b0;
				sda_d     = 1'b0;
				shift_d   = byte_for_step(step_q, req_rd_q, req_dev_q, req_reg_q, req_data_q);
				bit_cnt_d = '0;
				phase_d   = PH_BIT_LOW;
			end
			PH_BIT_LOW: begin
				scl_d   = 1'b0;
				sda_d   = shift_q[7];
				phase_d = PH_BIT_HIGH;
			end
			PH_BIT_HIGH: begin
				sda_d     = shift_q[7];
				shift_d   = {shift_q[6:0], 1'b0};
				bit_cnt_d = bit_cnt_q + 4'd1;
				phase_d   = (bit_cnt_d >= BITS_PER_BYTE) ? PH_ACK_RELEASE : PH_BIT_LOW;
			end
			PH_ACK_RELEASE: begin
				scl_d      = 1'b0;
				wait_cnt_d = '0;
				phase_d    = PH_ACK_WAIT;
			end
			PH_ACK_WAIT: begin
				if (!sda_in_s1) begin
					// acknowledged: next byte, repeated start, read or stop
					if (step_q == STEP_DEVICE) begin
						step_d    = STEP_REGISTER;
						shift_d   = req_reg_q;
						bit_cnt_d = '0;
						phase_d   = PH_BIT_LOW;
					end else if (step_q == STEP_REGISTER) begin
						step_d = STEP_PAYLOAD;
						if (req_rd_q) begin
							phase_d = PH_RESTART_LOW;
						end else begin
							shift_d   = req_data_q;
							bit_cnt_d = '0;
							phase_d   = PH_BIT_LOW;
						end
					end else if (req_rd_q) begin
						shift_d   = '0;
						bit_cnt_d = '0;
						phase_d   = PH_RD_LOW;
					end else begin
						phase_d = PH_STOP_LOW;
					end
				end else if (wait_cnt_q >= ack_timeout_q) begin
					// no acknowledge in time: abort with a stop
					fail_d  = 1'b1;
					phase_d = PH_STOP_LOW;
				end else begin
					wait_cnt_d = wait_cnt_q + 8'd1;
				end
			end
			PH_RD_LOW: begin
				scl_d   = 1'b0;
				phase_d = PH_RD_HIGH;
			end
			PH_RD_HIGH: begin
				shift_d   = {shift_q[6:0], sda_in_s1};
				bit_cnt_d = bit_cnt_q + 4'd1;
				if (bit_cnt_d >= BITS_PER_BYTE) begin
					rx_byte_d = shift_d;
					phase_d   = PH_NACK_LOW;
				end else begin
					phase_d = PH_RD_LOW;
				end
			end
			PH_NACK_LOW: begin
				scl_d   = 1'b0;
				phase_d = PH_NACK_HIGH;
			end
			PH_NACK_HIGH: begin
				phase_d = PH_STOP_LOW;
			end
			PH_STOP_LOW: begin
				scl_d   = 1'b0;
				sda_d   = 1'b0;
				phase_d = PH_STOP_RISE;
			end
			PH_STOP_RISE: begin
				sda_d   = 1'b0;
				phase_d = PH_STOP_END;
			end
			PH_STOP_END: begin
				done_d   = 1'b1;
				failed_d = fail_q;
				fail_d   = 1'b0;
				phase_d  = PH_IDLE;
			end
			default: begin
				// idle tick, lines released
				busy_d  = 1'b0;
				phase_d = PH_IDLE;
			end
		endcase
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			action_s1 <= action;
			dev_s1    <= device_address;
			reg_s1    <= register_address;
			data_s1   <= write_data;
			sda_in_s1 <= sda_in;
		end
	end

	// bus state and timeout register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_IDLE;
			bit_cnt_q     <= '0;
			step_q        <= STEP_DEVICE;
			shift_q       <= '0;
			wait_cnt_q    <= '0;
			req_rd_q      <= 1'b0;
			req_dev_q     <= '0;
			req_reg_q     <= '0;
			req_data_q    <= '0;
			rx_byte_q     <= '0;
			fail_q        <= 1'b0;
			ack_timeout_q <= ACK_TIMEOUT_RESET;
		end else begin
			if (advance) begin
				phase_q    <= phase_d;
				bit_cnt_q  <= bit_cnt_d;
				step_q     <= step_d;
				shift_q    <= shift_d;
				wait_cnt_q <= wait_cnt_d;
				req_rd_q   <= req_rd_d;
				req_dev_q  <= req_dev_d;
				req_reg_q  <= req_reg_d;
				req_data_q <= req_data_d;
				rx_byte_q  <= rx_byte_d;
				fail_q     <= fail_d;
			end
			if (cfg_we) begin
				ack_timeout_q <= cfg_wdata;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			scl_s2    <= scl_d;
			sda_s2    <= sda_d;
			busy_s2   <= busy_d;
			done_s2   <= done_d;
			failed_s2 <= failed_d;
			rx_s2     <= rx_byte_d;
		end
	end

	assign out_valid  = valid_s2;
	assign scl_level  = scl_s2;
	assign sda_level  = sda_s2;
	assign busy_res   = busy_s2;
	assign done_res   = done_s2;
	assign ack_failed = failed_s2;
	assign read_value = rx_s2;

	// a finishing tick is part of the transaction
	`I2CMRA_ASSERT_SAME(a_done_busy, clk, arst_n, valid_s2 && done_s2, busy_s2, "done without busy")
	// an abort is only reported on the finishing tick
	`I2CMRA_ASSERT_SAME(a_fail_done, clk, arst_n, valid_s2 && failed_s2, done_s2, "failure not on done")
	// idle ticks leave both lines released
	`I2CMRA_ASSERT_SAME(a_idle_lines, clk, arst_n, valid_s2 && !busy_s2, scl_s2 && sda_s2, "idle lines driven")
	// acknowledge wait never counts past the timeout
	`I2CMRA_ASSERT_SAME(a_wait_bound, clk, arst_n, phase_q == PH_ACK_WAIT, wait_cnt_q <= ack_timeout_q, "wait count overrun")
	// a stalled, full result register keeps the state machine still
	`I2CMRA_ASSERT_NEXT(a_stall_hold, clk, arst_n, valid_s2 && out_stall, phase_q == $past(phase_q), "state moved under stall")

endmodule

[sim/tb_i2c_master_register_access_top.sv]
// ----------------------------------------------------------------------------
// tb_i2c_master_register_access_top
// self-checking bench for the i2c register access master: a bus-level slave
// answers acknowledges and read bits, a tick-level model of the master
// predicts every result, and a short table of transactions runs first
// ----------------------------------------------------------------------------
module tb_i2c_master_register_access_top;
	timeunit 1ns;
	timeprecision 1ps;

	import i2cmra_pkg::*;

	localparam int      WATCHDOG_LIMIT = 4000;  // cycles with no request or result moving
	localparam int      SETTLE_CYCLES  = 6;     // two register stages plus margin
	localparam int      BURST_CYCLES   = 60;    // long receiver hold-off
	localparam action_t ACTION_UNUSED  = 2'd3;  // undefined code, acts as a plain tick

	// bus sequencer phases of the master
	typedef enum logic [4:0] {
		BP_IDLE, BP_RESTART_LOW, BP_START_HIGH, BP_START_FALL, BP_START_LOW,
		BP_BIT_LOW, BP_BIT_HIGH, BP_ACK_RELEASE, BP_ACK_WAIT, BP_RD_LOW, BP_RD_HIGH,
		BP_NACK_LOW, BP_NACK_HIGH, BP_STOP_LOW, BP_STOP_RISE, BP_STOP_END
	} bus_phase_e;

	// one tick of bus output as seen on the result channel
	typedef struct packed {
		logic  scl;
		logic  sda;
		logic  busy;
		logic  done;
		logic  failed;
		byte_t rd_value;
	} line_result_t;

	// one directed transaction: timeout setting, request, slave behavior,
	// and the closing result where it is obvious
	typedef struct {
		int unsigned timeout;
		action_t     act;
		action_t     busy_act;
		byte_t       dev;
		byte_t       regad;
		byte_t       data;
		int unsigned hold;
		byte_t       reply;
		bit          typed;
		bit          fail;
		byte_t       rd;
	} plan_row_t;

	logic    clk              = 1'b0;
	logic    arst_n           = 1'b0;
	logic    in_valid         = 1'b0;
	logic    in_stall;
	action_t action           = ACTION_TICK;
	byte_t   device_address   = 8'h00;
	byte_t   register_address = 8'h00;
	byte_t   write_data       = 8'h00;
	logic    sda_in           = 1'b1;
	logic    out_valid;
	logic    out_stall        = 1'b0;
	logic    scl_level;
	logic    sda_level;
	logic    busy_res;
	logic    done_res;
	logic    ack_failed;
	byte_t   read_value;
	logic    cfg_we           = 1'b0;
	byte_t   cfg_wdata        = 8'h00;

	// model state of the master
	bus_phase_e  m_phase   = BP_IDLE;
	logic [3:0]  m_bits    = '0;
	step_t       m_step    = STEP_DEVICE;
	byte_t       m_shift   = '0;
	byte_t       m_wait    = '0;
	byte_t       m_timeout = ACK_TIMEOUT_RESET;
	byte_t       m_dev     = '0;
	byte_t       m_reg     = '0;
	byte_t       m_data    = '0;
	byte_t       m_rx      = '0;
	logic        m_is_read = 1'b0;
	logic        m_fail    = 1'b0;

	// slave behavior: high acknowledge samples before pulling low, per byte,
	// and the byte it returns on a read
	int unsigned ack_hold [3];
	byte_t       slave_reply;
	bit          sda_noise;

	line_result_t expected_lines [$];
	line_result_t last_seen;
	int unsigned  tick_count;
	int unsigned  mismatch_count;
	int unsigned  quiet_cycles;
	int unsigned  tx_idle_pct;
	int unsigned  rx_idle_pct;
	int unsigned  burst_left;
	bit           burst_req;

	plan_row_t plan [15] = '{
		// idle line after reset, read byte still zero
		'{250, ACTION_TICK,   ACTION_TICK,   8'h00, 8'h00, 8'h00,  0, 8'h00, 1'b1, 1'b0, 8'h00},
		// undefined action behaves as a tick
		'{250, ACTION_UNUSED, ACTION_TICK,   8'hFF, 8'hFF, 8'hFF,  0, 8'h00, 1'b1, 1'b0, 8'h00},
		'{250, ACTION_WRITE,  ACTION_TICK,   8'h00, 8'h00, 8'h00,  0, 8'h00, 1'b1, 1'b0, 8'h00},
		// starts offered while busy are ignored
		'{250, ACTION_WRITE,  ACTION_READ,   8'hFF, 8'hFF, 8'hFF,  0, 8'h00, 1'b1, 1'b0, 8'h00},
		// device byte plus one wraps to zero
		'{250, ACTION_READ,   ACTION_WRITE,  8'hFF, 8'h00, 8'h00,  0, 8'hFF, 1'b1, 1'b0, 8'hFF},
		'{250, ACTION_READ,   ACTION_READ,   8'h00, 8'hFF, 8'hFF,  0, 8'h00, 1'b1, 1'b0, 8'h00},
		'{250, ACTION_READ,   ACTION_UNUSED, 8'hA0, 8'h5A, 8'hC3,  3, 8'hA5, 1'b0, 1'b0, 8'hA5},
		// acknowledge on the last allowed sample
		'{12,  ACTION_WRITE,  ACTION_TICK,   8'h6C, 8'h81, 8'h7E, 12, 8'h00, 1'b0, 1'b0, 8'hA5},
		// aborted read keeps the previous byte
		'{12,  ACTION_READ,   ACTION_TICK,   8'h12, 8'h34, 8'h56, 13, 8'h3C, 1'b1, 1'b1, 8'hA5},
		// zero timeout: first high sample aborts
		'{0,   ACTION_WRITE,  ACTION_WRITE,  8'h55, 8'hAA, 8'h55,  1, 8'h00, 1'b1, 1'b1, 8'hA5},
		'{0,   ACTION_READ,   ACTION_TICK,   8'hAA, 8'h55, 8'hAA,  0, 8'h3C, 1'b1, 1'b0, 8'h3C},
		'{9,   ACTION_WRITE,  ACTION_TICK,   8'h80, 8'h01, 8'h80,  9, 8'h00, 1'b0, 1'b0, 8'h3C},
		'{9,   ACTION_WRITE,  ACTION_TICK,   8'h01, 8'h80, 8'h01, 10, 8'h00, 1'b1, 1'b1, 8'h3C},
		'{1,   ACTION_READ,   ACTION_TICK,   8'h81, 8'h7E, 8'h00,  2, 8'h00, 1'b1, 1'b1, 8'h3C},
		'{1,   ACTION_WRITE,  ACTION_READ,   8'h7F, 8'h80, 8'h01,  1, 8'h00, 1'b1, 1'b0, 8'h3C}
	};

	i2c_master_register_access_top DUT (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.action           (action),
		.device_address   (device_address),
		.register_address (register_address),
		.write_data       (write_data),
		.sda_in           (sda_in),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.scl_level        (scl_level),
		.sda_level        (sda_level),
		.busy_res         (busy_res),
		.done_res         (done_res),
		.ack_failed       (ack_failed),
		.read_value       (read_value),
		.cfg_we           (cfg_we),
		.cfg_wdata        (cfg_wdata)
	);

	always #6 clk = ~clk;

	// one line per mismatch
	task automatic log_mismatch(string what, int unsigned want, int unsigned got);
		mismatch_count++;
		$display("mismatch %s at %0t: expected %0h, got %0h", what, $realtime, want, got);
	endtask

	// start shifting out one byte of the transaction
	function automatic void load_byte(step_t s);
		m_step = s;
		case (s)
			STEP_DEVICE:   m_shift = m_dev;
			STEP_REGISTER: m_shift = m_reg;
			default:       m_shift = m_is_read ? m_dev + 8'd1 : m_data;
		endcase
		m_bits  = '0;
		m_phase = BP_BIT_LOW;
	endfunction

	// advance the master model by one tick and return the line it drives
	function automatic line_result_t predict_bus_tick(action_t act, byte_t dev, byte_t regad,
			byte_t data, logic sda);
		line_result_t r;
		r = '{scl: 1'b1, sda: 1'b1, busy: 1'b1, done: 1'b0, failed: 1'b0, rd_value: 8'h00};
		// a start is taken only on an idle tick, and begins on that same tick
		if (m_phase == BP_IDLE && (act == ACTION_WRITE || act == ACTION_READ)) begin
			m_dev     = dev;
			m_reg     = regad;
			m_data    = data;
			m_is_read = (act == ACTION_READ);
			m_step    = STEP_DEVICE;
			m_bits    = '0;
			m_wait    = '0;
			m_fail    = 1'b0;
			m_phase   = BP_START_HIGH;
		end
		case (m_phase)
			BP_RESTART_LOW: begin
				r.scl = 1'b0;
				m_phase = BP_START_HIGH;
			end
			BP_START_HIGH: m_phase = BP_START_FALL;
			BP_START_FALL: begin
				r.sda = 1'b0;
				m_phase = BP_START_LOW;
			end
			BP_START_LOW: begin
				r.scl = 1'b0;
				r.sda = 1'b0;
				load_byte(m_step);
			end
			BP_BIT_LOW: begin
				r.scl = 1'b0;
				r.sda = m_shift[7];
				m_phase = BP_BIT_HIGH;
			end
			BP_BIT_HIGH: begin
				r.sda = m_shift[7];
				m_shift = m_shift << 1;
				m_bits++;
				m_phase = (m_bits >= BITS_PER_BYTE) ? BP_ACK_RELEASE : BP_BIT_LOW;
			end
			BP_ACK_RELEASE: begin
				r.scl = 1'b0;
				m_wait = '0;
				m_phase = BP_ACK_WAIT;
			end
			BP_ACK_WAIT: begin
				if (!sda) begin
					case (m_step)
						STEP_DEVICE: load_byte(STEP_REGISTER);
						STEP_REGISTER: begin
							if (m_is_read) begin
								m_step = STEP_PAYLOAD;
								m_phase = BP_RESTART_LOW;
							end else begin
								load_byte(STEP_PAYLOAD);
							end
						end
						default: begin
							if (m_is_read) begin
								m_shift = '0;
								m_bits = '0;
								m_phase = BP_RD_LOW;
							end else begin
								m_phase = BP_STOP_LOW;
							end
						end
					endcase
				end else if (m_wait >= m_timeout) begin
					m_fail = 1'b1;
					m_phase = BP_STOP_LOW;
				end else begin
					m_wait++;
				end
			end
			BP_RD_LOW: begin
				r.scl = 1'b0;
				m_phase = BP_RD_HIGH;
			end
			BP_RD_HIGH: begin
				m_shift = {m_shift[6:0], sda};
				m_bits++;
				if (m_bits >= BITS_PER_BYTE) begin
					m_rx = m_shift;
					m_phase = BP_NACK_LOW;
				end else begin
					m_phase = BP_RD_LOW;
				end
			end
			BP_NACK_LOW: begin
				r.scl = 1'b0;
				m_phase = BP_NACK_HIGH;
			end
			BP_NACK_HIGH: m_phase = BP_STOP_LOW;
			BP_STOP_LOW: begin
				r.scl = 1'b0;
				r.sda = 1'b0;
				m_phase = BP_STOP_RISE;
			end
			BP_STOP_RISE: begin
				r.sda = 1'b0;
				m_phase = BP_STOP_END;
			end
			BP_STOP_END: begin
				r.done = 1'b1;
				r.failed = m_fail;
				m_fail = 1'b0;
				m_phase = BP_IDLE;
			end
			default: begin
				r.busy = 1'b0;
				m_phase = BP_IDLE;
			end
		endcase
		r.rd_value = m_rx;
		return r;
	endfunction

	// slave side: level on sda for the next tick, from where the master stands
	function automatic logic slave_drive(bit scramble);
		if (scramble)
			return logic'($urandom_range(1));
		case (m_phase)
			BP_ACK_WAIT: return (int'(m_wait) >= ack_hold[m_step]) ? 1'b0 : 1'b1;
			BP_RD_HIGH:  return slave_reply[3'd7 - m_bits[2:0]];
			default:     return sda_noise ? logic'($urandom_range(1)) : 1'b1;
		endcase
	endfunction

	// offer one request, hold it until taken, then book its expected line
	task automatic push_request(action_t act, byte_t dev, byte_t regad, byte_t data,
			bit scramble);
		logic s;
		s = slave_drive(scramble);
		// random sender gaps, one drive of in_valid per edge
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid         <= 1'b1;
		action           <= act;
		device_address   <= dev;
		register_address <= regad;
		write_data       <= data;
		sda_in           <= s;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		expected_lines.push_back(predict_bus_tick(act, dev, regad, data, s));
		tick_count++;
	endtask

	// one start request, then ticks until the master is idle again
	task automatic run_transaction(action_t act, byte_t dev, byte_t regad, byte_t data,
			action_t busy_act, bit fill_random, bit scramble);
		action_t fa;
		byte_t   fd, fr, fw;
		push_request(act, dev, regad, data, scramble);
		while (m_phase != BP_IDLE) begin
			if (fill_random) begin
				fa = action_t'($urandom_range(3));
				fd = byte_t'($urandom);
				fr = byte_t'($urandom);
				fw = byte_t'($urandom);
			end else begin
				fa = busy_act;
				fd = ~dev;
				fr = ~regad;
				fw = ~data;
			end
			push_request(fa, fd, fr, fw, scramble);
		end
	endtask

	// stop offering and wait for every booked line to come back
	task automatic settle();
		in_valid <= 1'b0;
		while (expected_lines.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// timeout register is written only with the block drained
	task automatic load_timeout(byte_t value);
		settle();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		m_timeout = value;
	endtask

	// mostly well formed transactions with random content, some broken ones
	// and some loose ticks; one long receiver hold-off per call
	task automatic random_traffic(int unsigned budget);
		int unsigned first_tick, r, k;
		bit          burst_sent;
		action_t     la;
		first_tick = tick_count;
		burst_sent = 1'b0;
		while (tick_count - first_tick < budget) begin
			if (!burst_sent && tick_count - first_tick > budget / 3) begin
				burst_req = 1'b1;
				burst_sent = 1'b1;
			end
			r = $urandom_range(99);
			if (r < 85) begin
				// per byte: quick ack, short delay, last allowed sample, one too late
				for (k = 0; k < 3; k++) begin
					r = $urandom_range(99);
					if (r < 70)
						ack_hold[k] = 0;
					else if (r < 88)
						ack_hold[k] = $urandom_range(1, 4);
					else if (r < 95)
						ack_hold[k] = int'(m_timeout);
					else
						ack_hold[k] = int'(m_timeout) + 1;
				end
				slave_reply = byte_t'($urandom);
				la = $urandom_range(1) ? ACTION_READ : ACTION_WRITE;
				// a few transactions get a slave that drives garbage
				run_transaction(la, byte_t'($urandom), byte_t'($urandom), byte_t'($urandom),
					ACTION_TICK, 1'b1, $urandom_range(99) < 6);
			end else begin
				repeat ($urandom_range(1, 5)) begin
					la = $urandom_range(1) ? ACTION_TICK : ACTION_UNUSED;
					push_request(la, byte_t'($urandom), byte_t'($urandom), byte_t'($urandom),
						1'b0);
				end
			end
		end
	endtask

	// receiver: random stall, or a long hold-off when asked for one
	always @(posedge clk) begin
		if (burst_left > 0) begin
			out_stall <= 1'b1;
			burst_left--;
		end else if (burst_req) begin
			burst_req = 1'b0;
			burst_left = BURST_CYCLES - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < rx_idle_pct);
		end
	end

	// result checker: every accepted line against the oldest booked one
	always @(posedge clk) begin : result_check
		line_result_t want, got;
		if (arst_n && out_valid && !out_stall) begin
			got = {scl_level, sda_level, busy_res, done_res, ack_failed, read_value};
			if (expected_lines.size() == 0) begin
				log_mismatch("result with no request pending", 0, 32'(got));
			end else begin
				want = expected_lines.pop_front();
				if (got.scl !== want.scl)
					log_mismatch("scl_level", 32'(want.scl), 32'(got.scl));
				if (got.sda !== want.sda)
					log_mismatch("sda_level", 32'(want.sda), 32'(got.sda));
				if (got.busy !== want.busy)
					log_mismatch("busy_res", 32'(want.busy), 32'(got.busy));
				if (got.done !== want.done)
					log_mismatch("done_res", 32'(want.done), 32'(got.done));
				if (got.failed !== want.failed)
					log_mismatch("ack_failed", 32'(want.failed), 32'(got.failed));
				if (got.rd_value !== want.rd_value)
					log_mismatch("read_value", 32'(want.rd_value), 32'(got.rd_value));
			end
			last_seen = got;
		end
	end

	// watchdog: too long with nothing moving on either channel
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("i2c_master_register_access_top test failed");
			$finish;
		end
	end

	initial begin : stimulus
		line_result_t want_line;
		bit           starts;
		tx_idle_pct = 28;
		rx_idle_pct = 59;
		sda_noise   = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table, slave answers every byte with the same delay
		foreach (plan[i]) begin
			if (byte_t'(plan[i].timeout) != m_timeout)
				load_timeout(byte_t'(plan[i].timeout));
			ack_hold    = '{plan[i].hold, plan[i].hold, plan[i].hold};
			slave_reply = plan[i].reply;
			run_transaction(plan[i].act, plan[i].dev, plan[i].regad, plan[i].data,
				plan[i].busy_act, 1'b0, 1'b0);
			if (plan[i].typed) begin
				// closing line: stop end for a transaction, idle line for a tick
				settle();
				starts = (plan[i].act == ACTION_WRITE || plan[i].act == ACTION_READ);
				want_line = {1'b1, 1'b1, starts, starts, plan[i].fail, plan[i].rd};
				if (last_seen !== want_line)
					log_mismatch($sformatf("closing line of directed row %0d", i),
						32'(want_line), 32'(last_seen));
			end
		end

		// random part: receiver idles more first, then sender, then neither
		sda_noise = 1'b1;
		load_timeout(8'd1);
		random_traffic(100);
		tx_idle_pct = 59;
		rx_idle_pct = 28;
		load_timeout(8'd255);
		random_traffic(100);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		load_timeout(byte_t'($urandom_range(2, 20)));
		random_traffic(100);

		settle();
		if (mismatch_count == 0)
			$display("i2c_master_register_access_top test passed");
		else
			$display("i2c_master_register_access_top test failed");
		$finish;
	end

endmodule
